// File: design/tsc_pkg.sv
// Shared constants and types for the touch sample conditioner.
`default_nettype none
package tsc_pkg;

    // Raw conversion width on the stream and in the calibration registers
    localparam int SAMPLE_W = 12;
    // Signed width of a coordinate after invert and smoothing
    localparam int COORD_W  = 13;
    // Screen point width
    localparam int POINT_W  = 16;

    // Serial divider geometry: product magnitude over a 12 bit divisor
    localparam int DIV_NUM_W     = 26;
    localparam int DIV_DEN_W     = 12;
    localparam int DIV_STEP_BITS = 2;
    localparam int DIV_CYCLES    = DIV_NUM_W / DIV_STEP_BITS;
    localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_CAL_X_LOW   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CAL_X_HIGH  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CAL_Y_LOW   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CAL_Y_HIGH  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_W    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_H    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ORIENT      = 3'd6;

    // Orientation flag bits
    localparam int ORIENT_SWAP  = 0;
    localparam int ORIENT_INV_X = 1;
    localparam int ORIENT_INV_Y = 2;

    // Event kinds
    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_TOUCHED  = 2'd1;
    localparam logic [1:0] KIND_RELEASED = 2'd2;

    // Handshake between sequencer and divider
    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } div_rsp_t;

endpackage : tsc_pkg
`default_nettype wire

// File: design/tsc_div.sv
// Serial restoring divider, two quotient bits per cycle.
`default_nettype none
module tsc_div
    import tsc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    // Two shift, compare and subtract steps per cycle
    always_comb begin
        logic [DIV_DEN_W:0] trial;
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int i = 0; i < DIV_STEP_BITS; i++) begin
            trial    = {rem_next, quo_next[DIV_NUM_W-1]};
            quo_next = {quo_next[DIV_NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                rem_next    = DIV_DEN_W'(trial - {1'b0, den_reg});
                quo_next[0] = 1'b1;
            end else begin
                rem_next = trial[DIV_DEN_W-1:0];
            end
        end
    end

    // Load on start, iterate while busy, pulse done after the last step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_CYCLES - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            den_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule : tsc_div
`default_nettype wire

// File: design/touch_sample_conditioner.sv
// Flow: an accepted input word passes smoothing, then for each screen axis a multiply
// and a run of the serial divider (two quotient bits per cycle), before its result
// word is loaded into the output register that drives m_tdata.
// The input is not ready while a word is in work; a finished result waits in the
// output register while the next input word is taken.
// Reset: synchronous active-low aresetn restores calibration and filter state.
`default_nettype none
module touch_sample_conditioner
    import tsc_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int PRESS_LEVEL = 400,
    parameter int LIFT_LEVEL  = 200
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // sample_x_a, sample_x_b, sample_x_c, sample_y_a, sample_y_b, sample_y_c,
    // pressure_a, pressure_b, pressure_c (12 bits each, from bit 0 up)
    input  wire logic [111:0]          s_tdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // point_x, point_y, touched_at_x, touched_at_y, released_at_x,
    // released_at_y (16 bits signed each, from bit 0 up)
    output logic [95:0]                m_tdata,
    // touching (bit 0), event_kind (bits 2:1)
    output logic [2:0]                 m_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PREP   = 6'b000010,
        ST_MUL    = 6'b000100,
        ST_DSTART = 6'b001000,
        ST_DWAIT  = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

    localparam int PROD_W = 27;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
        (SAMPLE_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}}
                                  : SAMPLE_W'((32'd1 << SAMPLE_BITS) - 32'd1);
    localparam logic [SAMPLE_W:0] PRESS_LVL = (SAMPLE_W + 1)'(PRESS_LEVEL);
    localparam logic [SAMPLE_W:0] LIFT_LVL  = (SAMPLE_W + 1)'(LIFT_LEVEL);
    localparam logic [POINT_W-1:0] NO_POINT = {POINT_W{1'b1}};

    // Median of three by min and max
    function automatic logic [SAMPLE_W-1:0] mid3(input logic [SAMPLE_W-1:0] a,
                                                 input logic [SAMPLE_W-1:0] b,
                                                 input logic [SAMPLE_W-1:0] c);
        logic [SAMPLE_W-1:0] lo, hi, m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

    // Configuration registers
    logic [SAMPLE_W-1:0] cal_x_low_reg, cal_x_high_reg, cal_y_low_reg, cal_y_high_reg;
    logic [SAMPLE_W-1:0] screen_width_reg, screen_height_reg;
    logic [2:0]          orient_reg;

    // Sequencer and working registers
    state_t                     state_reg;
    logic                       axis_reg;
    logic signed [COORD_W-1:0]  x_reg, y_reg;
    logic [SAMPLE_W-1:0]        z_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [DIV_DEN_W-1:0]       den_reg;
    logic                       den_pos_reg;
    logic                       neg_reg;
    logic [POINT_W-1:0]         px_reg, py_reg;

    // Tracking state
    logic                       pressed_reg, pressed_next;
    logic signed [COORD_W-1:0]  smooth_x_reg, smooth_y_reg;
    logic [POINT_W-1:0]         start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic [POINT_W-1:0]         start_x_next, start_y_next, end_x_next, end_y_next;
    logic [1:0]                 kind_next;

    // Output register
    logic [95:0]                out_tdata_reg;
    logic [2:0]                 out_tuser_reg;
    logic                       m_tvalid_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                       in_accept;
    logic                       out_load;
    logic                       cfg_write;
    logic [REG_IDX_W-1:0]       cfg_idx;
    logic [SAMPLE_W-1:0]        med_x, med_y, med_z;
    logic signed [COORD_W-1:0]  ox, oy;
    logic signed [COORD_W:0]    dx, dy, sum_x, sum_y;
    logic signed [COORD_W-1:0]  v_sel;
    logic [SAMPLE_W-1:0]        lo_sel, hi_sel, size_sel;
    logic signed [COORD_W:0]    diff;
    logic signed [COORD_W-1:0]  size_m1;
    logic signed [COORD_W-1:0]  den_full;
    logic [PROD_W-1:0]          prod_mag;
    logic [DIV_NUM_W-1:0]       qmag;
    logic [POINT_W-1:0]         q_sat;
    logic [POINT_W-1:0]         pt_x, pt_y;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[APB_ADDR_W-1:2];

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_x_low_reg     <= '0;
            cal_x_high_reg    <= {SAMPLE_W{1'b1}};
            cal_y_low_reg     <= '0;
            cal_y_high_reg    <= {SAMPLE_W{1'b1}};
            screen_width_reg  <= SAMPLE_W'(100);
            screen_height_reg <= SAMPLE_W'(100);
            orient_reg        <= '0;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_CAL_X_LOW:  cal_x_low_reg     <= pwdata[SAMPLE_W-1:0];
                REG_CAL_X_HIGH: cal_x_high_reg    <= pwdata[SAMPLE_W-1:0];
                REG_CAL_Y_LOW:  cal_y_low_reg     <= pwdata[SAMPLE_W-1:0];
                REG_CAL_Y_HIGH: cal_y_high_reg    <= pwdata[SAMPLE_W-1:0];
                REG_SCREEN_W:   screen_width_reg  <= pwdata[SAMPLE_W-1:0];
                REG_SCREEN_H:   screen_height_reg <= pwdata[SAMPLE_W-1:0];
                REG_ORIENT:     orient_reg        <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        case (cfg_idx)
            REG_CAL_X_LOW:  prdata = APB_DATA_W'(cal_x_low_reg);
            REG_CAL_X_HIGH: prdata = APB_DATA_W'(cal_x_high_reg);
            REG_CAL_Y_LOW:  prdata = APB_DATA_W'(cal_y_low_reg);
            REG_CAL_Y_HIGH: prdata = APB_DATA_W'(cal_y_high_reg);
            REG_SCREEN_W:   prdata = APB_DATA_W'(screen_width_reg);
            REG_SCREEN_H:   prdata = APB_DATA_W'(screen_height_reg);
            REG_ORIENT:     prdata = APB_DATA_W'(orient_reg);
            default:        prdata = '0;
        endcase
    end

    // Medians and invert of the incoming word
    always_comb begin
        med_x = mid3(s_tdata[11:0] & SAMPLE_MASK, s_tdata[23:12] & SAMPLE_MASK,
                     s_tdata[35:24] & SAMPLE_MASK);
        med_y = mid3(s_tdata[47:36] & SAMPLE_MASK, s_tdata[59:48] & SAMPLE_MASK,
                     s_tdata[71:60] & SAMPLE_MASK);
        med_z = mid3(s_tdata[83:72] & SAMPLE_MASK, s_tdata[95:84] & SAMPLE_MASK,
                     s_tdata[107:96] & SAMPLE_MASK);
        ox = orient_reg[ORIENT_INV_X] ? $signed({1'b0, cal_x_high_reg}) - $signed({1'b0, med_x})
                                      : $signed({1'b0, med_x});
        oy = orient_reg[ORIENT_INV_Y] ? $signed({1'b0, cal_y_high_reg}) - $signed({1'b0, med_y})
                                      : $signed({1'b0, med_y});
    end

    // Quarter-step smoothing toward the new sample, shift keeps the sign
    always_comb begin
        dx    = $signed({x_reg[COORD_W-1], x_reg})
              - $signed({smooth_x_reg[COORD_W-1], smooth_x_reg});
        dy    = $signed({y_reg[COORD_W-1], y_reg})
              - $signed({smooth_y_reg[COORD_W-1], smooth_y_reg});
        sum_x = $signed({smooth_x_reg[COORD_W-1], smooth_x_reg}) + (dx >>> 2);
        sum_y = $signed({smooth_y_reg[COORD_W-1], smooth_y_reg}) + (dy >>> 2);
    end

    // Operand selection for the current axis
    always_comb begin
        v_sel    = axis_reg ? y_reg : x_reg;
        lo_sel   = axis_reg ? cal_y_low_reg : cal_x_low_reg;
        hi_sel   = axis_reg ? cal_y_high_reg : cal_x_high_reg;
        size_sel = axis_reg ? screen_height_reg : screen_width_reg;
        diff     = {v_sel[COORD_W-1], v_sel} - $signed({2'b00, lo_sel});
        size_m1  = $signed({1'b0, size_sel}) - 13'sd1;
        den_full = $signed({1'b0, hi_sel}) - $signed({1'b0, lo_sel});
        prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    end

    // Sign, saturate and zero on a non-positive divisor
    always_comb begin
        qmag = div_rsp.quotient;
        if (!den_pos_reg) begin
            q_sat = '0;
        end else if (!neg_reg) begin
            q_sat = (qmag > DIV_NUM_W'(32767)) ? 16'h7FFF : qmag[POINT_W-1:0];
        end else begin
            q_sat = (qmag > DIV_NUM_W'(32768)) ? 16'h8000 : POINT_W'(-qmag);
        end
    end

    assign div_req.start    = (state_reg == ST_DSTART);
    assign div_req.dividend = prod_mag[DIV_NUM_W-1:0];
    assign div_req.divisor  = den_reg;

    tsc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Press and lift decision with hysteresis
    always_comb begin
        pressed_next = pressed_reg;
        kind_next    = KIND_NONE;
        start_x_next = start_x_reg;
        start_y_next = start_y_reg;
        end_x_next   = end_x_reg;
        end_y_next   = end_y_reg;
        if (pressed_reg) begin
            if ({1'b0, z_reg} < LIFT_LVL) begin
                pressed_next = 1'b0;
                kind_next    = KIND_RELEASED;
                end_x_next   = px_reg;
                end_y_next   = py_reg;
            end
        end else if ({1'b0, z_reg} > PRESS_LVL) begin
            pressed_next = 1'b1;
            kind_next    = KIND_TOUCHED;
            start_x_next = px_reg;
            start_y_next = py_reg;
        end
        pt_x = pressed_next ? px_reg : NO_POINT;
        pt_y = pressed_next ? py_reg : NO_POINT;
    end

    // Sequencer and tracking state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            axis_reg     <= 1'b0;
            pressed_reg  <= 1'b0;
            smooth_x_reg <= '0;
            smooth_y_reg <= '0;
            start_x_reg  <= NO_POINT;
            start_y_reg  <= NO_POINT;
            end_x_reg    <= NO_POINT;
            end_y_reg    <= NO_POINT;
            m_tvalid_reg <= 1'b0;
        end else begin
            // Raise valid on a new result, drop it once the word is taken
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    if (pressed_reg) begin
                        smooth_x_reg <= sum_x[COORD_W-1:0];
                        smooth_y_reg <= sum_y[COORD_W-1:0];
                    end
                    axis_reg  <= 1'b0;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    state_reg <= ST_DSTART;
                end
                ST_DSTART: begin
                    state_reg <= ST_DWAIT;
                end
                ST_DWAIT: begin
                    if (div_rsp.done) begin
                        if (!axis_reg) begin
                            axis_reg  <= 1'b1;
                            state_reg <= ST_MUL;
                        end else begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        pressed_reg  <= pressed_next;
                        start_x_reg  <= start_x_next;
                        start_y_reg  <= start_y_next;
                        end_x_reg    <= end_x_next;
                        end_y_reg    <= end_y_next;
                        if (kind_next == KIND_RELEASED) begin
                            smooth_x_reg <= '1;
                            smooth_y_reg <= '1;
                        end else if (kind_next == KIND_TOUCHED) begin
                            smooth_x_reg <= x_reg;
                            smooth_y_reg <= y_reg;
                        end
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Working datapath registers
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            x_reg <= orient_reg[ORIENT_SWAP] ? oy : ox;
            y_reg <= orient_reg[ORIENT_SWAP] ? ox : oy;
            z_reg <= med_z;
        end
        if ((state_reg == ST_PREP) && pressed_reg) begin
            x_reg <= sum_x[COORD_W-1:0];
            y_reg <= sum_y[COORD_W-1:0];
        end
        if (state_reg == ST_MUL) begin
            prod_reg    <= PROD_W'(diff * size_m1);
            den_reg     <= den_full[DIV_DEN_W-1:0];
            den_pos_reg <= !den_full[COORD_W-1] && (den_full != '0);
        end
        if (state_reg == ST_DSTART) begin
            neg_reg <= prod_reg[PROD_W-1];
        end
        if ((state_reg == ST_DWAIT) && div_rsp.done) begin
            if (axis_reg) begin
                py_reg <= q_sat;
            end else begin
                px_reg <= q_sat;
            end
        end
        if (out_load) begin
            out_tdata_reg <= {end_y_next, end_x_next, start_y_next, start_x_next, pt_y, pt_x};
            out_tuser_reg <= {kind_next, pressed_next};
        end
    end

    assign m_tdata  = out_tdata_reg;
    assign m_tuser  = out_tuser_reg;
    assign m_tvalid = m_tvalid_reg;

`ifndef SYNTHESIS
    // A released word never reports the screen as pressed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && (m_tuser[2:1] == KIND_RELEASED)))
        else $error("released word marked as touching");

    // Without touch the current point is minus one on both axes
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[31:0] == 32'hFFFF_FFFF))
        else $error("idle word carries a point");

    // The divider only finishes while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DWAIT))
        else $error("divider done outside wait state");

    // An accepted word moves the sequencer into smoothing
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> (state_reg == ST_PREP))
        else $error("accepted word did not start processing");

    // A touch start word always reports the screen as pressed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[2:1] == KIND_TOUCHED)) |-> m_tuser[0])
        else $error("touch word not marked as touching");
`endif

endmodule : touch_sample_conditioner
`default_nettype wire

// File: sim/tb_touch_sample_conditioner.sv
// Self-checking stream testbench for the touch sample conditioner with an APB register path.
module tb_touch_sample_conditioner;
    import tsc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRESS_LEVEL = 400;
    localparam int LIFT_LEVEL  = 200;
    localparam int PHASES      = 13;
    localparam int PHASE_WORDS = 145;
    localparam int HOLD_CYCLES = 400;
    // Generous watchdog limit for about 2000 words with the longest sender gaps between them.
    localparam int CYCLE_LIMIT = 2_000_000;

    // One raw touch update, first sample in the lowest bits
    typedef struct packed {
        logic [SAMPLE_W-1:0] z_c, z_b, z_a, y_c, y_b, y_a, x_c, x_b, x_a;
    } raw_update_t;

    typedef struct {
        logic                      touching;
        logic [1:0]                kind;
        logic signed [POINT_W-1:0] pt_x, pt_y, start_x, start_y, rel_x, rel_y;
    } report_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic [111:0]          s_tdata  = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [95:0]           m_tdata;
    logic [2:0]            m_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    touch_sample_conditioner #(
        .SAMPLE_BITS (SAMPLE_W),
        .PRESS_LEVEL (PRESS_LEVEL),
        .LIFT_LEVEL  (LIFT_LEVEL)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Shadow of the calibration registers
    int         cfg_x_lo  = 0;
    int         cfg_x_hi  = 4095;
    int         cfg_y_lo  = 0;
    int         cfg_y_hi  = 4095;
    int         cfg_width = 100;
    int         cfg_height = 100;
    logic [2:0] cfg_orient = '0;

    // Pen tracking state
    bit pen_down = 1'b0;
    int filt_x   = 0;
    int filt_y   = 0;
    int touch_x  = -1;
    int touch_y  = -1;
    int lift_x   = -1;
    int lift_y   = -1;

    raw_update_t pending_updates[$];
    report_t     expected_reports[$];
    int          words_queued   = 0;
    int          words_accepted = 0;
    int          mismatches     = 0;
    int          cycles         = 0;
    bit          s_word_taken   = 1'b0;
    bit          no_idling      = 1'b0;
    int          gap_left       = 0;
    int          hold_requests  = 0;
    int          holds_served   = 0;
    int          hold_left      = 0;

    function automatic int median3(int a, int b, int c);
        if (a > b) begin
            return (b > c) ? b : ((a > c) ? c : a);
        end
        return (a > c) ? a : ((b > c) ? c : b);
    endfunction

    function automatic int wrap13(int v);
        logic signed [COORD_W-1:0] w;
        w = v[COORD_W-1:0];
        return w;
    endfunction

    // Map a coordinate to pixels, truncating toward zero and clamping to 16 bits
    function automatic int scale_axis(int v, int lo, int hi, int size);
        longint q;
        if (hi <= lo) return 0;
        q = (longint'(v) - lo) * (longint'(size) - 1) / (longint'(hi) - lo);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return int'(q);
    endfunction

    // Advance the pen state by one update and return the report it produces
    function automatic report_t track_touch(raw_update_t r);
        int x, y, z, t, px, py;
        report_t rep;
        x = median3(r.x_a, r.x_b, r.x_c);
        y = median3(r.y_a, r.y_b, r.y_c);
        z = median3(r.z_a, r.z_b, r.z_c);
        if (cfg_orient[ORIENT_INV_X]) x = cfg_x_hi - x;
        if (cfg_orient[ORIENT_INV_Y]) y = cfg_y_hi - y;
        if (cfg_orient[ORIENT_SWAP]) begin
            t = x;
            x = y;
            y = t;
        end
        // Smooth only while the pen was already down
        if (pen_down) begin
            filt_x = wrap13(filt_x + ((x - filt_x) >>> 2));
            filt_y = wrap13(filt_y + ((y - filt_y) >>> 2));
            x = filt_x;
            y = filt_y;
        end
        px = scale_axis(x, cfg_x_lo, cfg_x_hi, cfg_width);
        py = scale_axis(y, cfg_y_lo, cfg_y_hi, cfg_height);
        rep.kind = KIND_NONE;
        if (pen_down) begin
            if (z < LIFT_LEVEL) begin
                pen_down = 1'b0;
                lift_x = px;
                lift_y = py;
                filt_x = -1;
                filt_y = -1;
                rep.kind = KIND_RELEASED;
            end
        end else if (z > PRESS_LEVEL) begin
            pen_down = 1'b1;
            touch_x = px;
            touch_y = py;
            filt_x = wrap13(x);
            filt_y = wrap13(y);
            rep.kind = KIND_TOUCHED;
        end
        rep.touching = pen_down;
        rep.pt_x = pen_down ? px : -1;
        rep.pt_y = pen_down ? py : -1;
        rep.start_x = touch_x;
        rep.start_y = touch_y;
        rep.rel_x = lift_x;
        rep.rel_y = lift_y;
        return rep;
    endfunction

    task automatic check_field(string name, logic signed [31:0] want,
                               logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Three samples whose median is m, in random order
    function automatic logic [3*SAMPLE_W-1:0] spread3(int m);
        logic [SAMPLE_W-1:0] lo_v, hi_v, mid;
        lo_v = $urandom_range(m, 0);
        hi_v = $urandom_range(4095, m);
        mid = m;
        case ($urandom_range(5))
            0: return {hi_v, mid, lo_v};
            1: return {mid, hi_v, lo_v};
            2: return {hi_v, lo_v, mid};
            3: return {lo_v, hi_v, mid};
            4: return {mid, lo_v, hi_v};
            default: return {lo_v, mid, hi_v};
        endcase
    endfunction

    task automatic queue_raw(raw_update_t r);
        pending_updates.push_back(r);
        words_queued++;
    endtask

    task automatic queue_point(int x, int y, int z);
        raw_update_t r;
        {r.x_c, r.x_b, r.x_a} = spread3(x);
        {r.y_c, r.y_b, r.y_a} = spread3(y);
        {r.z_c, r.z_b, r.z_a} = spread3(z);
        queue_raw(r);
    endtask

    function automatic int nudge(int v);
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(4095) : v + $urandom_range(400) - 200;
        return (n < 0) ? 0 : ((n > 4095) ? 4095 : n);
    endfunction

    // Mostly press, drag, lift gestures with random content; some raw noise
    task automatic queue_gestures(int count);
        int made, x, y;
        raw_update_t r;
        made = 0;
        while (made < count) begin
            if ($urandom_range(99) < 15) begin
                r = raw_update_t'({$urandom, $urandom, $urandom, $urandom});
                queue_raw(r);
                made++;
            end else begin
                x = $urandom_range(4095);
                y = $urandom_range(4095);
                queue_point(x, y, $urandom_range(4095, PRESS_LEVEL + 1));
                made++;
                repeat ($urandom_range(12)) begin
                    x = nudge(x);
                    y = nudge(y);
                    queue_point(x, y, $urandom_range(4095, LIFT_LEVEL));
                    made++;
                end
                queue_point(nudge(x), nudge(y), $urandom_range(LIFT_LEVEL - 1, 0));
                made++;
                repeat ($urandom_range(2)) begin
                    queue_point($urandom_range(4095), $urandom_range(4095),
                                $urandom_range(PRESS_LEVEL, 0));
                    made++;
                end
            end
        end
    endtask

    // Write a register over APB, mirror it, then read it back
    task automatic write_reg(logic [REG_IDX_W-1:0] idx, int value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'({idx, 2'b00});
        pwdata <= APB_DATA_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_CAL_X_LOW:  cfg_x_lo = value;
            REG_CAL_X_HIGH: cfg_x_hi = value;
            REG_CAL_Y_LOW:  cfg_y_lo = value;
            REG_CAL_Y_HIGH: cfg_y_hi = value;
            REG_SCREEN_W:   cfg_width = value;
            REG_SCREEN_H:   cfg_height = value;
            REG_ORIENT:     cfg_orient = value[2:0];
            default: ;
        endcase
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
        psel <= 1'b1;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== APB_DATA_W'(value)) begin
            $error("prdata reg %0d: expected %0d, got %0d", idx, value, prdata);
            mismatches++;
        end
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait until every queued word is taken and every report has come back
    task automatic drain();
        do @(negedge aclk);
        while (words_accepted != words_queued || expected_reports.size() != 0);
    endtask

    // Sender: hold a word until taken, insert random gaps between words
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || s_word_taken)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_updates.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (!no_idling && $urandom_range(99) < 31) begin
                gap_left <= $urandom_range(70);
                s_tvalid <= 1'b0;
            end else begin
                s_tdata <= {4'b0, pending_updates.pop_front()};
                s_tvalid <= 1'b1;
            end
        end
    end

    // Receiver: random stalls, plus long hold-offs on request
    always @(negedge aclk) begin
        if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idling || ($urandom_range(99) >= 31);
        end
    end

    // Predict on each accepted input word, check each accepted result word
    always @(posedge aclk) begin
        report_t want, got;
        s_word_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            expected_reports.push_back(track_touch(raw_update_t'(s_tdata[107:0])));
            words_accepted++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_reports.size() == 0) begin
                $error("result word with no pending expectation");
                mismatches++;
            end else begin
                want = expected_reports.pop_front();
                got.touching = m_tuser[0];
                got.kind = m_tuser[2:1];
                got.pt_x = m_tdata[15:0];
                got.pt_y = m_tdata[31:16];
                got.start_x = m_tdata[47:32];
                got.start_y = m_tdata[63:48];
                got.rel_x = m_tdata[79:64];
                got.rel_y = m_tdata[95:80];
                check_field("touching", want.touching, got.touching);
                check_field("event_kind", want.kind, got.kind);
                check_field("point_x", want.pt_x, got.pt_x);
                check_field("point_y", want.pt_y, got.pt_y);
                check_field("touched_at_x", want.start_x, got.start_x);
                check_field("touched_at_y", want.start_y, got.start_y);
                check_field("released_at_x", want.rel_x, got.rel_x);
                check_field("released_at_y", want.rel_y, got.rel_y);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int ph, lx, hx, ly, hy, w, h;
        raw_update_t raw;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words under reset calibration: thresholds, extremes, smoothing
        raw = '0;
        queue_raw(raw);                         // no pressure, stay up
        queue_point(2048, 2048, PRESS_LEVEL);   // at press level, stay up
        queue_point(4095, 0, PRESS_LEVEL + 1);  // press just above level
        queue_point(0, 4095, LIFT_LEVEL);       // at lift level, stay down
        queue_point(1000, 3000, 4095);
        queue_point(1000, 3000, LIFT_LEVEL - 1); // lift just below level
        queue_point(3000, 1000, LIFT_LEVEL);    // up and between levels
        raw = '1;
        queue_raw(raw);                         // every sample at full scale
        queue_raw(raw);
        raw = '0;
        queue_raw(raw);                         // lift at zero pressure
        queue_point(0, 0, 4095);
        queue_point(4095, 4095, 300);           // down, inside hysteresis band
        queue_point(4095, 4095, 300);
        queue_point(0, 0, 0);
        raw = '0;
        raw.x_a = 4095;
        raw.y_b = 4095;
        raw.z_c = 4095;
        queue_raw(raw);                         // lone spikes rejected by median
        drain();

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin lx = 0;    hx = 4095; ly = 0;    hy = 4095; w = 4095; h = 4095; end
                1: begin lx = 0;    hx = 1;    ly = 4094; hy = 4095; w = 4095; h = 4095; end
                2: begin lx = 2048; hx = 2048; ly = 4095; hy = 0;    w = 1;    h = 1;    end
                3: begin lx = 100;  hx = 3900; ly = 0;    hy = 4095; w = 0;    h = 0;    end
                4: begin lx = 500;  hx = 3500; ly = 300;  hy = 3800; w = 320;  h = 240;  end
                5: begin lx = 200;  hx = 3900; ly = 150;  hy = 3950; w = 800;  h = 480;  end
                default: begin
                    lx = $urandom_range(3000);
                    hx = ($urandom_range(9) == 0) ? $urandom_range(lx)
                                                  : $urandom_range(4095, lx + 1);
                    ly = $urandom_range(3000);
                    hy = ($urandom_range(9) == 0) ? $urandom_range(ly)
                                                  : $urandom_range(4095, ly + 1);
                    w = $urandom_range(1) ? $urandom_range(640, 1) : $urandom_range(4095, 1);
                    h = $urandom_range(1) ? $urandom_range(480, 1) : $urandom_range(4095, 1);
                end
            endcase
            write_reg(REG_CAL_X_LOW, lx);
            write_reg(REG_CAL_X_HIGH, hx);
            write_reg(REG_CAL_Y_LOW, ly);
            write_reg(REG_CAL_Y_HIGH, hy);
            write_reg(REG_SCREEN_W, w);
            write_reg(REG_SCREEN_H, h);
            write_reg(REG_ORIENT, ph % 8);
            @(posedge aclk);
            no_idling = (ph == 3);
            queue_gestures(PHASE_WORDS);
            // Stall the sink while words keep coming so the input backs up
            if (ph == 2 || ph == 9) hold_requests++;
            drain();
            no_idling = 1'b0;
        end

        repeat (60) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
